>>> rtl/sequential_list_engine_top_macros.svh
// ----------------------------------------------------------------------------
// Sequential list engine assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_ENGINE_TOP_MACROS_SVH
`define SEQUENTIAL_LIST_ENGINE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLST_ASSERT_SAME_CYCLE(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLST_ASSERT_NEXT_CYCLE(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/slst_pkg.sv
// ----------------------------------------------------------------------------
// Sequential list engine package
// Field widths, command and status codes, and the controller/datapath types.
// ----------------------------------------------------------------------------
`default_nettype none

package slst_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int CMD_W  = 3;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int STS_W  = 2;
    localparam int FPOS_W = 6;
    localparam int LEN_W  = 7;
    localparam int CAP_W  = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 3'd0,
        CMD_FIND    = 3'd1,
        CMD_READ    = 3'd2,
        CMD_RMV_VAL = 3'd3,
        CMD_RMV_IDX = 3'd4
    } t_cmd;

    typedef enum logic [STS_W-1:0] {
        STS_OK        = 2'd0,
        STS_BAD_POS   = 2'd1,
        STS_FULL      = 2'd2,
        STS_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_RDWAIT,
        S_SHUP,
        S_SHDN,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_LEN,
        IDX_ZERO,
        IDX_POS1,
        IDX_HIT1,
        IDX_INC,
        IDX_DEC
    } t_idx_sel;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_IDX_M1,
        RD_POS
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_UP,
        WR_DN,
        WR_VAL
    } t_wr_sel;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_RD_POS,
        RES_HIT,
        RES_INS
    } t_res_sel;

    typedef enum logic [1:0] {
        LEN_HOLD,
        LEN_INC,
        LEN_DEC
    } t_len_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_item;
        logic     set_status;
        t_status  status;
        t_idx_sel idx_sel;
        logic     rd_en;
        t_rd_sel  rd_sel;
        t_wr_sel  wr_sel;
        t_res_sel res_sel;
        t_len_op  len_op;
        logic     out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             pos_gt_len;
        logic             pos_ge_len;
        logic             full;
        logic             idx_gt_pos;
        logic             idx_lt_len;
        logic             rd_vld;
        logic             hit;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> rtl/slst_cmd_if.sv
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one list command item.
// ----------------------------------------------------------------------------
`default_nettype none

interface slst_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [slst_pkg::CMD_W-1:0]        command;
    logic [slst_pkg::POS_W-1:0]        position;
    logic signed [slst_pkg::VAL_W-1:0] value;

    modport source (output valid, output command, output position, output value,
                    input ready);
    modport sink   (input valid, input command, input position, input value,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/slst_rsp_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one list result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface slst_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [slst_pkg::STS_W-1:0]        status;
    logic [slst_pkg::FPOS_W-1:0]       found_position;
    logic signed [slst_pkg::VAL_W-1:0] found_value;
    logic [slst_pkg::LEN_W-1:0]        length;

    modport source (output valid, output status, output found_position,
                    output found_value, output length, input ready);
    modport sink   (input valid, input status, input found_position,
                    input found_value, input length, output ready);
endinterface

`default_nettype wire

>>> rtl/sequential_list_engine_top.sv
// The engine handles one item at a time and takes the next only once the result of the
// last has been registered. The walk over the entry store (one read and one write port)
// moves one entry per cycle. Reset (i_rst_n low, synchronous) empties the list, sets the
// capacity to 64 and drops any pending result.
// ----------------------------------------------------------------------------
// Sequential list engine top level
// Ordered list of signed 32-bit values with insert, find, read and remove.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sequential_list_engine_top_macros.svh"

module sequential_list_engine_top #(
    parameter int DEPTH = slst_pkg::DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [slst_pkg::CAP_W-1:0] i_cfg_wr_data,
    slst_cmd_if.sink                        i_cmd,
    slst_rsp_if.source                      o_rsp
);

    // The controller walks each command through the datapath. An item is taken
    // only in the idle state. Insert shifts later entries up one slot, working
    // from the tail down; the read of one entry overlaps the write of the one
    // before it, so the shift moves one entry per cycle. Find streams the
    // store from the head and compares each registered read against the value;
    // remove then shifts the tail down in the same overlapped way.
    // The finished result sits in an output register, so a new item can be
    // accepted while the previous result still waits for the sink.

    slst_pkg::t_dp_cmd dp_cmd;
    slst_pkg::t_dp_sts dp_sts;
    slst_pkg::t_status out_status;
    logic              in_ready;
    logic              out_valid;

    slst_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (out_valid),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    slst_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_command        (i_cmd.command),
        .i_position       (i_cmd.position),
        .i_value          (i_cmd.value),
        .i_cmd            (dp_cmd),
        .o_sts            (dp_sts),
        .o_status         (out_status),
        .o_found_position (o_rsp.found_position),
        .o_found_value    (o_rsp.found_value),
        .o_length         (o_rsp.length)
    );

    assign i_cmd.ready  = in_ready;
    assign o_rsp.valid  = out_valid;
    assign o_rsp.status = out_status;

    // Once an item is taken, the block is busy in the following cycle.
    `SLST_ASSERT_NEXT_CYCLE(a_busy_after_accept, i_cmd.valid && in_ready, !in_ready, "item accepted while busy")

    // A shifted entry is only written from a read that actually returned data.
    `SLST_ASSERT_SAME_CYCLE(a_shift_has_data, dp_cmd.wr_sel == slst_pkg::WR_UP || dp_cmd.wr_sel == slst_pkg::WR_DN, dp_sts.rd_vld, "shift write without read data")

    // A failed command reports zero position and value.
    `SLST_ASSERT_SAME_CYCLE(a_error_zero_fields, out_valid && out_status != slst_pkg::STS_OK, o_rsp.found_position == '0 && o_rsp.found_value == '0, "error result carries data")

endmodule

`default_nettype wire

>>> rtl/slst_datapath.sv
// ----------------------------------------------------------------------------
// Sequential list engine datapath
// Entry store, length and capacity registers, walk index, result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module slst_datapath #(
    parameter int DEPTH = slst_pkg::DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [slst_pkg::CAP_W-1:0]        i_cfg_wr_data,
    input  wire logic [slst_pkg::CMD_W-1:0]        i_command,
    input  wire logic [slst_pkg::POS_W-1:0]        i_position,
    input  wire logic signed [slst_pkg::VAL_W-1:0] i_value,
    input  wire slst_pkg::t_dp_cmd                 i_cmd,
    output slst_pkg::t_dp_sts                      o_sts,
    output slst_pkg::t_status                      o_status,
    output logic [slst_pkg::FPOS_W-1:0]            o_found_position,
    output logic signed [slst_pkg::VAL_W-1:0]      o_found_value,
    output logic [slst_pkg::LEN_W-1:0]             o_length
);

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW  = $clog2(DEPTH + 1);
    localparam int CW0 = (LW > slst_pkg::POS_W) ? LW : slst_pkg::POS_W;
    localparam int CW  = (CW0 > slst_pkg::LEN_W) ? CW0 : slst_pkg::LEN_W;

    // Item and configuration registers.
    logic [slst_pkg::CMD_W-1:0]        r_cmd;
    logic [slst_pkg::POS_W-1:0]        r_pos;
    logic signed [slst_pkg::VAL_W-1:0] r_val;
    logic [slst_pkg::CAP_W-1:0]        r_cap;
    logic [LW-1:0]                     r_len;
    logic [LW-1:0]                     r_idx;
    logic [LW-1:0]                     n_idx;

    // Store and its registered read port.
    logic signed [slst_pkg::VAL_W-1:0] r_mem [DEPTH];
    logic signed [slst_pkg::VAL_W-1:0] r_rdata;
    logic [AW-1:0]                     r_rd_idx;
    logic                              r_rd_vld;

    // Working result and output registers.
    slst_pkg::t_status                 r_res_status;
    logic [AW-1:0]                     r_res_fpos;
    logic signed [slst_pkg::VAL_W-1:0] r_res_fval;
    slst_pkg::t_status                 r_out_status;
    logic [slst_pkg::FPOS_W-1:0]       r_out_fpos;
    logic signed [slst_pkg::VAL_W-1:0] r_out_fval;
    logic [slst_pkg::LEN_W-1:0]        r_out_len;

    logic [CW-1:0]                     pos_w;
    logic [CW-1:0]                     len_w;
    logic [CW-1:0]                     idx_w;
    logic [CW-1:0]                     cap_w;
    logic [CW-1:0]                     eff_cap;
    logic [CW-1:0]                     fpos_w;
    logic [AW-1:0]                     pos_addr;
    logic [LW-1:0]                     idx_m1;
    logic [AW-1:0]                     rd_addr;
    logic                              wr_en;
    logic [AW-1:0]                     wr_addr;
    logic signed [slst_pkg::VAL_W-1:0] wr_data;

    always_comb begin
        pos_w    = CW'(r_pos);
        len_w    = CW'(r_len);
        idx_w    = CW'(r_idx);
        cap_w    = CW'(r_cap);
        eff_cap  = (cap_w > CW'(DEPTH)) ? CW'(DEPTH) : cap_w;
        pos_addr = pos_w[AW-1:0];
        idx_m1   = r_idx - LW'(1);
        fpos_w   = CW'(r_res_fpos);
    end

    always_comb begin
        o_sts.cmd        = r_cmd;
        o_sts.pos_gt_len = (pos_w > len_w);
        o_sts.pos_ge_len = (pos_w >= len_w);
        o_sts.full       = (len_w >= eff_cap);
        o_sts.idx_gt_pos = (idx_w > pos_w);
        o_sts.idx_lt_len = (r_idx < r_len);
        o_sts.rd_vld     = r_rd_vld;
        o_sts.hit        = r_rd_vld && (r_rdata == r_val);
    end

    always_comb begin
        case (i_cmd.rd_sel)
            slst_pkg::RD_IDX:    rd_addr = r_idx[AW-1:0];
            slst_pkg::RD_IDX_M1: rd_addr = idx_m1[AW-1:0];
            slst_pkg::RD_POS:    rd_addr = pos_addr;
            default:             rd_addr = r_idx[AW-1:0];
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = pos_addr;
        wr_data = r_val;
        case (i_cmd.wr_sel)
            slst_pkg::WR_UP: begin
                wr_addr = r_rd_idx + AW'(1);
                wr_data = r_rdata;
            end
            slst_pkg::WR_DN: begin
                wr_addr = r_rd_idx - AW'(1);
                wr_data = r_rdata;
            end
            slst_pkg::WR_VAL: begin
                wr_addr = pos_addr;
                wr_data = r_val;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.idx_sel)
            slst_pkg::IDX_LEN:  n_idx = r_len;
            slst_pkg::IDX_ZERO: n_idx = '0;
            slst_pkg::IDX_POS1: n_idx = LW'(pos_w + CW'(1));
            slst_pkg::IDX_HIT1: n_idx = LW'(r_rd_idx) + LW'(1);
            slst_pkg::IDX_INC:  n_idx = r_idx + LW'(1);
            slst_pkg::IDX_DEC:  n_idx = idx_m1;
            default:            n_idx = r_idx;
        endcase
    end

    // Store: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata  <= r_mem[rd_addr];
            r_rd_idx <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= slst_pkg::CAP_RESET;
            r_len    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            case (i_cmd.len_op)
                slst_pkg::LEN_INC: r_len <= r_len + LW'(1);
                slst_pkg::LEN_DEC: r_len <= r_len - LW'(1);
                default:           r_len <= r_len;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load_item) begin
            r_cmd        <= i_command;
            r_pos        <= i_position;
            r_val        <= i_value;
            r_res_status <= slst_pkg::STS_OK;
            r_res_fpos   <= '0;
            r_res_fval   <= '0;
        end else begin
            if (i_cmd.set_status) begin
                r_res_status <= i_cmd.status;
            end
            case (i_cmd.res_sel)
                slst_pkg::RES_RD_POS: begin
                    r_res_fpos <= pos_addr;
                    r_res_fval <= r_rdata;
                end
                slst_pkg::RES_HIT: begin
                    r_res_fpos <= r_rd_idx;
                    r_res_fval <= r_rdata;
                end
                slst_pkg::RES_INS: begin
                    r_res_fpos <= pos_addr;
                    r_res_fval <= r_val;
                end
                default: begin
                    r_res_fpos <= r_res_fpos;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_fpos   <= fpos_w[slst_pkg::FPOS_W-1:0];
            r_out_fval   <= r_res_fval;
            r_out_len    <= len_w[slst_pkg::LEN_W-1:0];
        end
    end

    assign o_status         = r_out_status;
    assign o_found_position = r_out_fpos;
    assign o_found_value    = r_out_fval;
    assign o_length         = r_out_len;

endmodule

`default_nettype wire

>>> rtl/slst_controller.sv
// ----------------------------------------------------------------------------
// Sequential list engine controller
// Sequences each command over the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module slst_controller (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    input  wire slst_pkg::t_dp_sts i_sts,
    output slst_pkg::t_dp_cmd      o_cmd
);

    slst_pkg::t_state r_state;
    slst_pkg::t_state n_state;
    logic             r_out_vld;
    logic             out_free;

    assign out_free = !r_out_vld || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            slst_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = slst_pkg::S_CHECK;
                end
            end
            slst_pkg::S_CHECK: begin
                case (i_sts.cmd)
                    slst_pkg::CMD_INSERT: begin
                        if (i_sts.pos_gt_len || i_sts.full) begin
                            n_state = slst_pkg::S_DONE;
                        end else begin
                            n_state = slst_pkg::S_SHUP;
                        end
                    end
                    slst_pkg::CMD_FIND, slst_pkg::CMD_RMV_VAL: begin
                        n_state = slst_pkg::S_SEARCH;
                    end
                    slst_pkg::CMD_READ, slst_pkg::CMD_RMV_IDX: begin
                        if (i_sts.pos_ge_len) begin
                            n_state = slst_pkg::S_DONE;
                        end else begin
                            n_state = slst_pkg::S_RDWAIT;
                        end
                    end
                    default: begin
                        n_state = slst_pkg::S_DONE;
                    end
                endcase
            end
            slst_pkg::S_SEARCH: begin
                if (i_sts.hit) begin
                    if (i_sts.cmd == slst_pkg::CMD_RMV_VAL) begin
                        n_state = slst_pkg::S_SHDN;
                    end else begin
                        n_state = slst_pkg::S_DONE;
                    end
                end else if (!i_sts.idx_lt_len && !i_sts.rd_vld) begin
                    n_state = slst_pkg::S_DONE;
                end
            end
            slst_pkg::S_RDWAIT: begin
                if (i_sts.cmd == slst_pkg::CMD_RMV_IDX) begin
                    n_state = slst_pkg::S_SHDN;
                end else begin
                    n_state = slst_pkg::S_DONE;
                end
            end
            slst_pkg::S_SHUP: begin
                if (!i_sts.idx_gt_pos && !i_sts.rd_vld) begin
                    n_state = slst_pkg::S_DONE;
                end
            end
            slst_pkg::S_SHDN: begin
                if (!i_sts.idx_lt_len && !i_sts.rd_vld) begin
                    n_state = slst_pkg::S_DONE;
                end
            end
            slst_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = slst_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = slst_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd.load_item  = 1'b0;
        o_cmd.set_status = 1'b0;
        o_cmd.status     = slst_pkg::STS_OK;
        o_cmd.idx_sel    = slst_pkg::IDX_HOLD;
        o_cmd.rd_en      = 1'b0;
        o_cmd.rd_sel     = slst_pkg::RD_IDX;
        o_cmd.wr_sel     = slst_pkg::WR_NONE;
        o_cmd.res_sel    = slst_pkg::RES_NONE;
        o_cmd.len_op     = slst_pkg::LEN_HOLD;
        o_cmd.out_load   = 1'b0;
        case (r_state)
            slst_pkg::S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            slst_pkg::S_CHECK: begin
                case (i_sts.cmd)
                    slst_pkg::CMD_INSERT: begin
                        if (i_sts.pos_gt_len) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = slst_pkg::STS_BAD_POS;
                        end else if (i_sts.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = slst_pkg::STS_FULL;
                        end else begin
                            o_cmd.idx_sel = slst_pkg::IDX_LEN;
                        end
                    end
                    slst_pkg::CMD_FIND, slst_pkg::CMD_RMV_VAL: begin
                        o_cmd.idx_sel = slst_pkg::IDX_ZERO;
                    end
                    slst_pkg::CMD_READ, slst_pkg::CMD_RMV_IDX: begin
                        if (i_sts.pos_ge_len) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = slst_pkg::STS_BAD_POS;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = slst_pkg::RD_POS;
                        end
                    end
                    default: begin
                        o_cmd.set_status = 1'b0;
                    end
                endcase
            end
            slst_pkg::S_SEARCH: begin
                // Reads run one entry ahead of the compare.
                if (i_sts.hit) begin
                    o_cmd.res_sel = slst_pkg::RES_HIT;
                    o_cmd.idx_sel = slst_pkg::IDX_HIT1;
                end else if (i_sts.idx_lt_len) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_sel  = slst_pkg::RD_IDX;
                    o_cmd.idx_sel = slst_pkg::IDX_INC;
                end else if (!i_sts.rd_vld) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = slst_pkg::STS_NOT_FOUND;
                end
            end
            slst_pkg::S_RDWAIT: begin
                o_cmd.res_sel = slst_pkg::RES_RD_POS;
                o_cmd.idx_sel = slst_pkg::IDX_POS1;
            end
            slst_pkg::S_SHUP: begin
                if (i_sts.rd_vld) begin
                    o_cmd.wr_sel = slst_pkg::WR_UP;
                end
                if (i_sts.idx_gt_pos) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_sel  = slst_pkg::RD_IDX_M1;
                    o_cmd.idx_sel = slst_pkg::IDX_DEC;
                end else if (!i_sts.rd_vld) begin
                    o_cmd.wr_sel  = slst_pkg::WR_VAL;
                    o_cmd.res_sel = slst_pkg::RES_INS;
                    o_cmd.len_op  = slst_pkg::LEN_INC;
                end
            end
            slst_pkg::S_SHDN: begin
                if (i_sts.rd_vld) begin
                    o_cmd.wr_sel = slst_pkg::WR_DN;
                end
                if (i_sts.idx_lt_len) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_sel  = slst_pkg::RD_IDX;
                    o_cmd.idx_sel = slst_pkg::IDX_INC;
                end else if (!i_sts.rd_vld) begin
                    o_cmd.len_op = slst_pkg::LEN_DEC;
                end
            end
            slst_pkg::S_DONE: begin
                o_cmd.out_load = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= slst_pkg::S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

`default_nettype wire

>>> dv/tb_sequential_list_engine_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sequential list engine testbench
// Drives list commands through the valid/ready command channel with random
// gaps and random result back-pressure. A scoreboard keeps its own copy of the
// list and the capacity, predicts every result as commands are accepted, and
// checks each result field by field. Directed corner cases run first, then
// random phases under several capacity settings.
// ----------------------------------------------------------------------------
module tb_sequential_list_engine_top;
    import slst_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 3;
    localparam int IDLE_PCT      = 29;
    localparam int SETTLE_CYCLES = 4;
    // A remove by value or an insert at the head walks the whole list.
    localparam int DRAIN_CYCLES  = DEPTH_DEF + 16;
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int NUM_PHASES    = 9;
    // The largest position the field can carry.
    localparam logic [POS_W-1:0] POS_TOP = POS_W'((1 << POS_W) - 1);

    // Each random phase has a capacity, a share of inserts and a length.
    // A capacity of -1 means a random legal capacity is picked for the phase.
    localparam int PHASE_CAP   [NUM_PHASES] = '{5, 127, 64, 1, 0, 65, 20, -1, 64};
    localparam int PHASE_INS   [NUM_PHASES] = '{55, 60, 25, 50, 40, 65, 30, 50, 45};
    localparam int PHASE_ITEMS [NUM_PHASES] = '{150, 300, 200, 100, 80, 300, 200, 250, 270};
    // The phase with this index runs without any idling on either side.
    localparam int CALM_PHASE  = 5;

    // One result item as the list engine should report it.
    typedef struct packed {
        logic [STS_W-1:0]        status;
        logic [FPOS_W-1:0]       position;
        logic signed [VAL_W-1:0] value;
        logic [LEN_W-1:0]        length;
    } t_list_result;

    // The scoreboard holds a shadow copy of the list. Each accepted command is
    // applied to the shadow list at once, and the result it should produce is
    // queued until the engine reports it.
    class t_list_scoreboard;
        logic signed [VAL_W-1:0] slots [DEPTH_DEF];
        int unsigned             fill;
        logic [CAP_W-1:0]        capacity;
        t_list_result            awaited[$];
        int unsigned             mismatches;

        function new();
            fill       = 0;
            capacity   = CAP_RESET;
            mismatches = 0;
        endfunction

        function bit quiet();
            return awaited.size() == 0;
        endfunction

        // Close the gap left by a removed entry.
        function void drop_slot(int unsigned at);
            for (int unsigned i = at; i + 1 < fill; i++)
                slots[i] = slots[i + 1];
            fill--;
        endfunction

        function t_list_result run_list_command(logic [CMD_W-1:0] cmd,
                                                logic [POS_W-1:0] pos,
                                                logic signed [VAL_W-1:0] val);
            t_list_result r;
            int unsigned  limit;
            int           at;
            r     = '0;
            limit = (capacity > DEPTH_DEF) ? DEPTH_DEF : capacity;
            at    = -1;
            case (cmd)
                CMD_INSERT: begin
                    // A position past the end wins over a full list.
                    if (pos > fill) begin
                        r.status = STS_BAD_POS;
                    end else if (fill >= limit) begin
                        r.status = STS_FULL;
                    end else begin
                        for (int unsigned i = fill; i > pos; i--)
                            slots[i] = slots[i - 1];
                        slots[pos] = val;
                        fill++;
                        r.position = pos[FPOS_W-1:0];
                        r.value    = val;
                    end
                end
                CMD_FIND, CMD_RMV_VAL: begin
                    // The lowest matching position counts.
                    for (int i = 0; i < int'(fill) && at < 0; i++)
                        if (slots[i] == val)
                            at = i;
                    if (at < 0) begin
                        r.status = STS_NOT_FOUND;
                    end else begin
                        r.position = FPOS_W'(at);
                        r.value    = slots[at];
                        if (cmd == CMD_RMV_VAL)
                            drop_slot(at);
                    end
                end
                CMD_READ, CMD_RMV_IDX: begin
                    if (pos >= fill) begin
                        r.status = STS_BAD_POS;
                    end else begin
                        r.position = pos[FPOS_W-1:0];
                        r.value    = slots[pos];
                        if (cmd == CMD_RMV_IDX)
                            drop_slot(pos);
                    end
                end
                default: ;
            endcase
            r.length = LEN_W'(fill);
            return r;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                   logic signed [VAL_W-1:0] val);
            awaited.push_back(run_list_command(cmd, pos, val));
        endfunction

        function void check_result(logic [STS_W-1:0] status, logic [FPOS_W-1:0] position,
                                   logic signed [VAL_W-1:0] value, logic [LEN_W-1:0] length);
            t_list_result want;
            if (awaited.size() == 0) begin
                $error("result with nothing pending: status %0d position %0d value %0d length %0d",
                       status, position, value, length);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                mismatches++;
            end
            if (position !== want.position) begin
                $error("found_position: expected %0d, got %0d", want.position, position);
                mismatches++;
            end
            if (value !== want.value) begin
                $error("found_value: expected %0d, got %0d", want.value, value);
                mismatches++;
            end
            if (length !== want.length) begin
                $error("length: expected %0d, got %0d", want.length, length);
                mismatches++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [CAP_W-1:0] i_cfg_wr_data;

    slst_cmd_if cmd_ch ();
    slst_rsp_if rsp_ch ();

    t_list_scoreboard sb;

    // When set, neither the command side nor the result side idles.
    bit          calm;
    int unsigned cycle_count;

    sequential_list_engine_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd_ch),
        .o_rsp         (rsp_ch)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // The run ends here, reporting a mismatch, once the cycle count reaches LIMIT_CYCLES.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("sequential_list_engine_top: mismatch");
            $finish;
        end
    end

    // The result side stalls at random, with odds of IDLE_PCT in a hundred,
    // except while calm. Ready changes only at the falling edge.
    always @(negedge i_clk) begin
        rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Results are taken at the rising edge, where the handshake completes.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.status, rsp_ch.found_position,
                            rsp_ch.found_value, rsp_ch.length);
    end

    // Offers one command item and returns at the falling edge after it has
    // been accepted. Valid stays high on return, so that back-to-back items
    // never lower and raise it within one time step; the next call lowers it
    // only when it decides to idle first.
    task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                            input logic signed [VAL_W-1:0] v);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.command  <= c;
        cmd_ch.position <= p;
        cmd_ch.value    <= v;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sb.note_command(c, p, v);
        @(negedge i_clk);
    endtask

    // The capacity is written only while the engine is idle: the command
    // channel is closed and every pending result has been collected.
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        cmd_ch.valid <= 1'b0;
        while (!sb.quiet())
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= cap;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.capacity = cap;
    endtask

    // Values lean toward a small set so that duplicates are common, with the
    // extremes of the signed range mixed in.
    function automatic logic signed [VAL_W-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            return VAL_W'($urandom_range(0, 7));
        if (roll < 34)
            return 32'sh8000_0000;
        if (roll < 38)
            return 32'sh7fff_ffff;
        if (roll < 42)
            return -32'sd1;
        return $urandom;
    endfunction

    // Most commands are well formed against the current shadow list: inserts
    // at a legal position, reads and removes at a live index, searches for a
    // value that is present. The rest use any position or value the fields
    // allow, and a few carry an unused command code.
    task automatic pick_command(input int insert_pct, output logic [CMD_W-1:0] c,
                                output logic [POS_W-1:0] p,
                                output logic signed [VAL_W-1:0] v);
        int unsigned len;
        int unsigned roll;
        len  = sb.fill;
        v    = pick_value();
        p    = POS_W'($urandom_range(0, (1 << POS_W) - 1));
        roll = $urandom_range(0, 99);
        if (roll < insert_pct) begin
            c = CMD_INSERT;
            if ($urandom_range(0, 9) != 0)
                p = POS_W'($urandom_range(0, len));
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                c = CMD_W'($urandom_range(int'(CMD_RMV_IDX) + 1, (1 << CMD_W) - 1));
            else if (roll < 28)
                c = CMD_FIND;
            else if (roll < 52)
                c = CMD_READ;
            else if (roll < 76)
                c = CMD_RMV_VAL;
            else
                c = CMD_RMV_IDX;
            if ((c == CMD_READ || c == CMD_RMV_IDX) && len > 0 && $urandom_range(0, 9) != 0)
                p = POS_W'($urandom_range(0, len - 1));
            if ((c == CMD_FIND || c == CMD_RMV_VAL) && len > 0 && $urandom_range(0, 4) != 0)
                v = sb.slots[$urandom_range(0, len - 1)];
        end
    endtask

    initial begin
        logic [CMD_W-1:0]        c;
        logic [POS_W-1:0]        p;
        logic signed [VAL_W-1:0] v;
        int                      cap;

        sb              = new();
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.command  = '0;
        cmd_ch.position = '0;
        cmd_ch.value    = '0;
        rsp_ch.ready    = 1'b0;
        calm            = 1'b0;
        cycle_count     = 0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, starting from the empty list and the reset capacity.
        // Every command against the empty list fails.
        send_cmd(CMD_READ, 0, 0);
        send_cmd(CMD_RMV_IDX, 0, 0);
        send_cmd(CMD_FIND, 0, 0);
        send_cmd(CMD_RMV_VAL, 0, 0);
        send_cmd(CMD_INSERT, 1, 0);
        // Build a short list holding both extremes of the value range, a
        // duplicate, an insert at the head and one at the tail.
        send_cmd(CMD_INSERT, 0, 32'sh8000_0000);
        send_cmd(CMD_INSERT, 1, 32'sh7fff_ffff);
        send_cmd(CMD_INSERT, 0, -32'sd1);
        send_cmd(CMD_INSERT, 3, 0);
        send_cmd(CMD_INSERT, POS_TOP, 5);
        send_cmd(CMD_INSERT, 1, 32'sh7fff_ffff);
        // The duplicate must be found at its lowest position.
        send_cmd(CMD_FIND, 0, 32'sh7fff_ffff);
        send_cmd(CMD_READ, POS_TOP, 0);
        send_cmd(CMD_READ, 4, 0);
        send_cmd(CMD_READ, 5, 0);
        // Unused command codes change nothing and still answer.
        send_cmd(CMD_W'(int'(CMD_RMV_IDX) + 1), POS_TOP, -32'sd1);
        send_cmd(CMD_W'(int'(CMD_RMV_IDX) + 2), 3, 32'sh7fff_ffff);
        send_cmd(CMD_W'((1 << CMD_W) - 1), 0, 32'sh8000_0000);
        send_cmd(CMD_RMV_VAL, 0, 32'sh7fff_ffff);
        send_cmd(CMD_RMV_IDX, 0, 0);
        send_cmd(CMD_FIND, 0, 12345);
        // A capacity below the current length makes the list full, but a
        // position past the end is still reported as a bad position first.
        set_capacity(2);
        send_cmd(CMD_INSERT, POS_TOP, 7);
        send_cmd(CMD_INSERT, 0, 7);
        set_capacity(0);
        send_cmd(CMD_INSERT, 3, 9);
        send_cmd(CMD_RMV_IDX, 2, 0);

        // Random phases. Each one sets a capacity, then leans toward growing
        // or shrinking the list so that lengths sweep from empty to full.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            cap = (PHASE_CAP[ph] < 0) ? $urandom_range(2, DEPTH_DEF) : PHASE_CAP[ph];
            set_capacity(CAP_W'(cap));
            calm = (ph == CALM_PHASE);
            for (int n = 0; n < PHASE_ITEMS[ph]; n++) begin
                pick_command(PHASE_INS[ph], c, p, v);
                send_cmd(c, p, v);
            end
            calm = 1'b0;
        end

        // Close the channel, collect every pending result, then watch a while
        // longer for anything the engine should not have produced.
        cmd_ch.valid <= 1'b0;
        while (!sb.quiet())
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0)
            $display("sequential_list_engine_top: match");
        else
            $display("sequential_list_engine_top: mismatch");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/slst_pkg.sv
rtl/slst_cmd_if.sv
rtl/slst_rsp_if.sv
rtl/slst_datapath.sv
rtl/slst_controller.sv
rtl/sequential_list_engine_top.sv
dv/tb_sequential_list_engine_top.sv
